// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the block distance design.
// Needs nothing else; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mbd_pkg.sv =====
// Types and constants of the block distance design.
// Depends on nothing; the top level, the checker and the result and config interfaces import it.
package mbd_pkg;

  // Field widths of the transactions.
  localparam int VALUE_W    = 16;
  localparam int DIST_W     = 31;
  localparam int IDX_W      = 31;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register widths.
  localparam int BB_W = 5;
  localparam int IB_W = 20;
  localparam int TB_W = 30;

  // Reset values of the configuration registers.
  localparam logic [BB_W-1:0] BB_RST = 5'd8;
  localparam logic [IB_W-1:0] IB_RST = 20'd2560;
  localparam logic [TB_W-1:0] TB_RST = 30'd256000;

  // Result queue depth and its occupancy threshold for taking a new bit.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;
  localparam logic [FIFO_CW-1:0] FIFO_ACCEPT_MAX = 3'(FIFO_DEPTH - 2);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_BITS  = 2'd0,
    REG_INIT_BLOCKS = 2'd1,
    REG_TEST_BLOCKS = 2'd2
  } cfg_reg_t;

  // One result item.
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [VALUE_W-1:0] block_value;
    logic               last;
  } res_t;

endpackage

// ===== src/mbd_in_if.sv =====
// Input bit channel of the block distance design.
// Depends on nothing; the payload is a single bit.
interface mbd_in_if;

  logic valid;
  logic ready;
  logic bit_in;

  modport source (output valid, output bit_in, input ready);
  modport sink (input valid, input bit_in, output ready);

endinterface

// ===== src/mbd_out_if.sv =====
// Result channel of the block distance design.
// Depends on mbd_pkg for the field widths.
interface mbd_out_if;
  import mbd_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  distance;
  logic [VALUE_W-1:0] block_value;
  logic               last;

  modport source (output valid, output distance, output block_value, output last,
                  input ready);
  modport sink (input valid, input distance, input block_value, input last,
                output ready);

endinterface

// ===== src/mbd_cfg_if.sv =====
// Configuration write channel of the block distance design.
// Depends on mbd_pkg for the index and data widths.
interface mbd_cfg_if;
  import mbd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);

endinterface

// ===== src/maurer_block_distance.sv =====
// Top level of the block distance design: bit packing, last-seen table, result queue.
// Depends on mbd_pkg and the interfaces mbd_in_if, mbd_out_if and mbd_cfg_if.
//
//   channel  port    direction  carries
//   input    in_s    sink       bit_in, one bit per transaction
//   result   out_m   source     distance, block_value, last
//   config   cfg_s   sink       index, data (always ready)
//
// One bit is taken per cycle while in_s is ready; a completed block reads the
// last-seen table in its cycle and writes it back in the next, with forwarding between blocks.
// A result passes the write-back stage and the result queue before it reaches out_m.
// After reset the table is swept to zero, all 2^MAX_BLOCK_BITS entries, with in_s not ready.
// in_s stalls during the sweep and when the four-entry result queue holds more than two results.
module maurer_block_distance #(
  parameter int MAX_BLOCK_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  mbd_in_if.sink     in_s,
  mbd_out_if.source  out_m,
  mbd_cfg_if.sink    cfg_s
);
  import mbd_pkg::*;

  localparam int AW    = MAX_BLOCK_BITS;
  localparam int DEPTH = 1 << AW;

  // Configuration registers.
  logic [BB_W-1:0] block_bits_r;
  logic [IB_W-1:0] init_blocks_r;
  logic [TB_W-1:0] test_blocks_r;

  // Packing state.
  logic [AW-1:0]    acc_r;
  logic [CNT_W-1:0] bit_cnt_r;
  logic [IDX_W-1:0] blk_idx_r;

  // Table clearing sweep.
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // Last-seen table and its registered read data.
  logic [IDX_W-1:0] table_mem [DEPTH];
  logic [IDX_W-1:0] mem_rd_r;

  // Write-back stage.
  logic             b_valid_r;
  logic [AW-1:0]    b_addr_r;
  logic [IDX_W-1:0] b_idx_r;
  logic             b_emit_r;
  logic             b_last_r;
  logic             fwd_hit_r;
  logic [IDX_W-1:0] fwd_idx_r;

  // Result queue.
  res_t                 fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   fifo_cnt_r;

  logic [CNT_W-1:0] eff_w;
  logic [IDX_W-1:0] total_w;
  logic             run_done;
  logic             accept;
  logic [CNT_W-1:0] cnt_inc;
  logic [AW:0]      acc_cat;
  logic [AW-1:0]    acc_shift;
  logic [AW-1:0]    value_mask;
  logic [AW-1:0]    value;
  logic             blk_done;
  logic             blk_emit;
  logic             blk_last;
  logic [IDX_W-1:0] prev_idx;
  logic             push;
  logic             pop;
  res_t             push_res;

  // Configuration writes; indexes beyond the list are dropped.
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bits_r  <= BB_RST;
      init_blocks_r <= IB_RST;
      test_blocks_r <= TB_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_BLOCK_BITS:  block_bits_r  <= cfg_s.data[BB_W-1:0];
        REG_INIT_BLOCKS: init_blocks_r <= cfg_s.data[IB_W-1:0];
        REG_TEST_BLOCKS: test_blocks_r <= cfg_s.data[TB_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective block width, clamped to 1..MAX_BLOCK_BITS.
  always_comb begin
    priority if (block_bits_r == '0) begin
      eff_w = CNT_W'(1);
    end else if (block_bits_r > BB_W'(MAX_BLOCK_BITS)) begin
      eff_w = CNT_W'(MAX_BLOCK_BITS);
    end else begin
      eff_w = block_bits_r;
    end
  end

  // Run bounds and the block that the current bit may complete.
  assign total_w   = IDX_W'(init_blocks_r) + IDX_W'(test_blocks_r);
  assign run_done  = blk_idx_r >= total_w;
  assign accept    = in_s.valid && in_s.ready;
  assign cnt_inc   = bit_cnt_r + CNT_W'(1);
  assign acc_cat   = {acc_r, in_s.bit_in};
  assign acc_shift = acc_cat[AW-1:0];
  assign blk_done  = accept && !run_done && (cnt_inc >= eff_w);
  assign blk_emit  = blk_idx_r >= IDX_W'(init_blocks_r);
  assign blk_last  = (blk_idx_r + IDX_W'(1)) == total_w;

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      value_mask[i] = (CNT_W'(i) < eff_w);
    end
  end

  assign value = acc_shift & value_mask;

  // Bit packing and block counting; bits past the run are taken and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      bit_cnt_r <= '0;
      blk_idx_r <= '0;
    end else if (accept && !run_done) begin
      if (blk_done) begin
        acc_r     <= '0;
        bit_cnt_r <= '0;
        blk_idx_r <= blk_idx_r + IDX_W'(1);
      end else begin
        acc_r     <= acc_shift;
        bit_cnt_r <= cnt_inc;
      end
    end
  end

  // Zeroing sweep over the table after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Table read for a completed block.
  always_ff @(posedge clk) begin
    if (blk_done) begin
      mem_rd_r <= table_mem[value];
    end
  end

  // Table write: the sweep, else the write-back of the block in stage two.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      table_mem[clr_addr_r] <= '0;
    end else if (b_valid_r) begin
      table_mem[b_addr_r] <= b_idx_r;
    end
  end

  // Write-back stage; a hit records the write landing on the same edge as the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= blk_done;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_done) begin
      b_addr_r  <= value;
      b_idx_r   <= blk_idx_r;
      b_emit_r  <= blk_emit;
      b_last_r  <= blk_last;
      fwd_hit_r <= b_valid_r && (b_addr_r == value);
      fwd_idx_r <= b_idx_r;
    end
  end

  assign prev_idx = fwd_hit_r ? fwd_idx_r : mem_rd_r;

  always_comb begin
    push_res.distance    = b_idx_r - prev_idx;
    push_res.block_value = VALUE_W'(b_addr_r);
    push_res.last        = b_last_r;
  end

  // Result queue between the write-back stage and the output channel.
  assign push = b_valid_r && b_emit_r;
  assign pop  = out_m.valid && out_m.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  assign out_m.valid       = fifo_cnt_r != '0;
  assign out_m.distance    = fifo_mem[rd_ptr_r].distance;
  assign out_m.block_value = fifo_mem[rd_ptr_r].block_value;
  assign out_m.last        = fifo_mem[rd_ptr_r].last;

  // A new bit is taken only after the sweep and when the queue has room for the stage-two result and its own.
  assign in_s.ready = !clearing_r && (fifo_cnt_r <= FIFO_ACCEPT_MAX);

endmodule

// ===== src/mbd_checker.sv =====
// Port-level checks of maurer_block_distance, attached by the bind below.
// Depends on mbd_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module mbd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mbd_pkg::DIST_W-1:0]  distance,
  input logic [mbd_pkg::VALUE_W-1:0] block_value,
  input logic                        last
);
  import mbd_pkg::*;

  // Straight after reset the table sweep runs: no bit taken, no result shown.
  `MBD_ASSERT_IMP(a_quiet_after_reset, clk, rst_n, $past(!rst_n), !in_ready && !out_valid, "busy right after reset")

  // An empty queue fills only from a taken bit, through the write-back stage and the queue.
  `MBD_ASSERT_IMP(a_result_has_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a completing bit")

  // A stalled result stays offered.
  `MBD_ASSERT_NXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `MBD_ASSERT_NXT(a_out_payload_holds, clk, rst_n, out_valid && !out_ready, $stable(distance) && $stable(block_value) && $stable(last), "result changed while stalled")

endmodule

bind maurer_block_distance mbd_checker u_mbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_s.valid),
  .in_ready    (in_s.ready),
  .out_valid   (out_m.valid),
  .out_ready   (out_m.ready),
  .distance    (out_m.distance),
  .block_value (out_m.block_value),
  .last        (out_m.last)
);
